// ===== rtl/rdc_pkg.sv =====
// Shared widths, base-select codes and base decode functions for the radix digit converter.
package rdc_pkg;

  localparam int VALUE_W       = 32;
  localparam int OPCODE_W      = 2;
  localparam int DIGIT_W       = 4;
  localparam int RADIX_W       = 5;
  localparam int SHIFT_W       = 3;
  localparam int DEFAULT_WIDTH = 32;
  localparam int BITS_PER_STEP = 8;

  localparam logic [OPCODE_W-1:0] OP_BIN = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_OCT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DEC = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_HEX = 2'd3;

  function automatic logic [RADIX_W-1:0] radix_of(input logic [OPCODE_W-1:0] code);
    logic [RADIX_W-1:0] r;
    unique case (code)
      OP_BIN:  r = 5'd2;
      OP_OCT:  r = 5'd8;
      OP_DEC:  r = 5'd10;
      OP_HEX:  r = 5'd16;
      default: r = 5'd16;
    endcase
    return r;
  endfunction

  // Shift amount for the power-of-two bases; decimal has none.
  function automatic logic [SHIFT_W-1:0] shift_of(input logic [OPCODE_W-1:0] code);
    logic [SHIFT_W-1:0] s;
    unique case (code)
      OP_BIN:  s = 3'd1;
      OP_OCT:  s = 3'd3;
      OP_DEC:  s = 3'd0;
      OP_HEX:  s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/radix_digit_converter_top.sv =====
// Top level of the radix digit converter: input handshake, digit store and output register.
//
// A word on the input channel carries a signed value and a two-bit base select (binary, octal,
// decimal, hexadecimal). The block answers with one output word per digit of the absolute
// value, most significant digit first; is_last marks the least significant digit. Zero gives
// a single digit 0, and the most negative value is converted as the magnitude 2^(WIDTH-1).
// Only the low WIDTH bits of value are used, with bit WIDTH-1 as the sign.
//
// Digits are produced least significant first by a shared divider and kept in a small RAM,
// then read back in reverse. For binary, octal and hexadecimal the divider takes each digit
// from a shift and a mask; for decimal it works through eight dividend bits a cycle.
// Reading back passes through the S_READ and S_LOAD states for each digit via the registered
// RAM port, and waits in S_LOAD while the output register is still full.
// in_ready is high only while no item is being converted or read back.
//
// The output word sits in a register: when the receiver stalls the word holds and reading
// back pauses, while a new input word is still taken once the last digit of the previous
// item has reached the output register. Reset empties the output register and returns the
// sequencer to idle; the digit RAM needs no clearing since every entry read is first written.
module radix_digit_converter_top #(
  parameter int WIDTH = rdc_pkg::DEFAULT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rdc_pkg::VALUE_W-1:0]  value,
  input  logic [rdc_pkg::OPCODE_W-1:0] opcode,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rdc_pkg::DIGIT_W-1:0]  digit,
  output logic                         is_last
);
  import rdc_pkg::*;

  localparam int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int EXT_W = (WIDTH > VALUE_W) ? WIDTH : VALUE_W;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_READ, S_LOAD} state_t;

  state_t              state;
  logic [OPCODE_W-1:0] op;
  logic [IDX_W-1:0]    wr_idx;
  logic [IDX_W-1:0]    rd_idx;

  logic                accept;
  logic [EXT_W-1:0]    value_ext;
  logic [WIDTH-1:0]    raw;
  logic [WIDTH-1:0]    mag;

  logic                div_start;
  logic [OPCODE_W-1:0] div_code;
  logic [WIDTH-1:0]    div_dividend;
  logic                div_busy;
  logic                div_done;
  logic [WIDTH-1:0]    div_quo;
  logic [DIGIT_W-1:0]  div_rem;
  logic                div_more;

  logic                ram_we;
  logic [DIGIT_W-1:0]  ram_rdata;
  logic                load_out;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Magnitude of the low WIDTH bits taken as a two's complement number. Negating the most
  // negative pattern gives it back, which read unsigned is exactly 2^(WIDTH-1).
  assign value_ext = EXT_W'(value);
  assign raw       = value_ext[WIDTH-1:0];
  assign mag       = raw[WIDTH-1] ? (~raw + 1'b1) : raw;

  // The divider is restarted in the very cycle it reports a quotient that is not yet zero.
  assign div_more     = (state == S_DIV) && div_done && (div_quo != '0);
  assign div_start    = accept || div_more;
  assign div_code     = accept ? opcode : op;
  assign div_dividend = accept ? mag : div_quo;

  assign ram_we = (state == S_DIV) && div_done;

  // A digit read back from the RAM moves into the output register once the slot is free.
  assign load_out = (state == S_LOAD) && (!out_valid || out_ready);

  rdc_divider #(.WIDTH(WIDTH)) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .code      (div_code),
    .dividend  (div_dividend),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  rdc_ram #(.DATA_W(DIGIT_W), .DEPTH(WIDTH), .ADDR_W(IDX_W)) u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (div_rem),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wr_idx    <= '0;
      rd_idx    <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op     <= opcode;
            wr_idx <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_quo == '0) begin
              rd_idx <= wr_idx;
              state  <= S_READ;
            end else begin
              wr_idx <= wr_idx + 1'b1;
            end
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          // The RAM word for rd_idx is on ram_rdata now; move it out once the slot is free.
          if (load_out) begin
            digit   <= ram_rdata;
            is_last <= (rd_idx == '0);
            if (rd_idx == '0) begin
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx - 1'b1;
              state  <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider result arrived outside the divide phase");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_DIV) && (div_busy || div_done))
    else $error("accepted word did not start the divider");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) && (!out_valid || out_ready) && (rd_idx == '0)
      |=> out_valid && is_last && (state == S_IDLE))
    else $error("final digit not flagged or sequencer not back to idle");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while running");

endmodule

// ===== rtl/rdc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module rdc_ram #(
  parameter int DATA_W = 4,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rdc_divider.sv =====
// Iterative divider by a small base: one step per power-of-two base, eight dividend bits per
// cycle for decimal.
module rdc_divider #(
  parameter int WIDTH = rdc_pkg::DEFAULT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rdc_pkg::OPCODE_W-1:0] code,
  input  logic [WIDTH-1:0]             dividend,
  output logic                         busy,
  output logic                         done,
  output logic [WIDTH-1:0]             quotient,
  output logic [rdc_pkg::DIGIT_W-1:0]  remainder
);
  import rdc_pkg::*;

  localparam int CHUNKS = (WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_W  = CHUNKS * BITS_PER_STEP;
  localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t              state;
  logic [PAD_W-1:0]     q;
  logic [DIGIT_W-1:0]   rem;
  logic [RADIX_W-1:0]   base;
  logic [CNT_W-1:0]     cnt;

  logic [BITS_PER_STEP-1:0]       chunk;
  logic [BITS_PER_STEP-1:0]       qbits;
  logic [RADIX_W-1:0]             r;
  logic [PAD_W+BITS_PER_STEP-1:0] shifted;
  logic [RADIX_W-1:0]             start_radix;
  logic [WIDTH-1:0]               pow2_quo;

  // Eight restoring steps on a five-bit partial remainder.
  always_comb begin
    chunk = q[PAD_W-1 -: BITS_PER_STEP];
    r     = {1'b0, rem};
    qbits = '0;
    for (int i = BITS_PER_STEP - 1; i >= 0; i--) begin
      r = {r[DIGIT_W-1:0], chunk[i]};
      if (r >= base) begin
        r        = r - base;
        qbits[i] = 1'b1;
      end
    end
    shifted = {q, qbits};
  end

  assign start_radix = radix_of(code);
  assign pow2_quo    = dividend >> shift_of(code);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (start) begin
            base <= start_radix;
            if (code == OP_DEC) begin
              q     <= PAD_W'(dividend);
              rem   <= '0;
              cnt   <= '0;
              done  <= 1'b0;
              state <= D_RUN;
            end else begin
              q    <= PAD_W'(pow2_quo);
              rem  <= dividend[DIGIT_W-1:0] & DIGIT_W'(start_radix - 5'd1);
              done <= 1'b1;
            end
          end else begin
            done <= 1'b0;
          end
        end
        D_RUN: begin
          q   <= shifted[PAD_W-1:0];
          rem <= r[DIGIT_W-1:0];
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(CHUNKS - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            done <= 1'b0;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= D_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state == D_RUN);
  assign quotient  = q[WIDTH-1:0];
  assign remainder = rem;

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    done |-> {1'b0, rem} < base)
    else $error("divider remainder not below base");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("divider done raised while still running");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    busy |=> busy || done)
    else $error("divider left run without done");

endmodule

// ===== tb/tb_radix_digit_converter_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the radix digit converter, covering directed and random words.
module tb_radix_digit_converter_top;
  import rdc_pkg::*;

  // The run is stopped outright if it has not drained by this many cycles. The slowest
  // correct run is about 470 words of 32 binary digits under heavy back-pressure.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int NUM_DIRECTED  = 25;
  localparam int WORDS_PER_PHASE = 112;
  localparam int DRAIN_CYCLES  = 120;

  // One row of the directed stimulus. Where num_digits is non-zero, the expected digits
  // are typed in as nibbles, most significant first. Otherwise the predictor supplies them.
  typedef struct packed {
    logic [VALUE_W-1:0]  val;
    logic [OPCODE_W-1:0] op;
    logic [7:0]          num_digits;
    logic [127:0]        nibbles;
  } stim_row_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] dig;
    logic               last;
  } digit_word_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [VALUE_W-1:0]  value;
  logic [OPCODE_W-1:0] opcode;
  logic                out_valid;
  logic                out_ready;
  logic [DIGIT_W-1:0]  digit;
  logic                is_last;

  digit_word_t pending_digits[$];
  stim_row_t   dir_rows [NUM_DIRECTED];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned digits_checked;
  int unsigned words_per_base [4];
  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct;

  radix_digit_converter_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .digit     (digit),
    .is_last   (is_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog counts every cycle and ends the run if the block stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d digits still awaited.",
               cycle_count, pending_digits.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Works out the digits of the absolute value of v in the base chosen by op and queues
  // them most significant first. The most negative value negates to itself, which read as
  // unsigned is exactly its magnitude of 2^31.
  function automatic void predict_digits(input logic [VALUE_W-1:0] v,
                                         input logic [OPCODE_W-1:0] op);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] radix;
    logic [DIGIT_W-1:0] lsd_first [64];
    int                 count;
    digit_word_t        w;
    count = 0;
    case (op)
      OP_BIN:  radix = 2;
      OP_OCT:  radix = 8;
      OP_DEC:  radix = 10;
      default: radix = 16;
    endcase
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
    do begin
      lsd_first[count] = DIGIT_W'(mag % radix);
      mag = mag / radix;
      count++;
    end while (mag != 0 && count < 64);
    for (int k = 0; k < count; k++) begin
      w.dig  = lsd_first[count - 1 - k];
      w.last = (k == count - 1);
      pending_digits.push_back(w);
    end
  endfunction

  // Presents one word on the input channel and returns once it has been taken. A random
  // gap of idle cycles may come first. When there is no gap the new word replaces the old
  // one in the same step that the old one was accepted, so valid stays high throughout.
  task automatic send_word(input logic [VALUE_W-1:0] v, input logic [OPCODE_W-1:0] op);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    opcode   <= op;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    words_per_base[op]++;
  endtask

  // Holds the sender back until every queued digit has been seen at the output.
  task automatic wait_drained();
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  // Picks a value so that the random words reach beyond uniform noise: small numbers and
  // their negatives give short runs and single digits, the extremes give the longest
  // runs, and values near powers of two and of ten sit on the digit-count boundaries.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(40);
      2: v = -$urandom_range(40);
      3: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h8000_0001;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      4: v = (32'd1 << $urandom_range(31)) - $urandom_range(1);
      default: begin
        p = 1;
        repeat ($urandom_range(9)) p = p * 10;
        v = p - $urandom_range(1);
      end
    endcase
    if ($urandom_range(3) == 0) v = -v;
    return v;
  endfunction

  // The receiver takes a word at every edge where it and the block agree, compares it
  // with the oldest expectation and then decides at random whether to stall next cycle.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_digits.size() == 0) begin
          $display("%0t: unexpected word, no digit awaited: digit %0d is_last %0b",
                   $time, digit, is_last);
          error_count++;
        end else begin
          digit_word_t exp_w;
          exp_w = pending_digits.pop_front();
          if (digit !== exp_w.dig) begin
            $display("%0t: digit mismatch: expected %0d, got %0d", $time, exp_w.dig, digit);
            error_count++;
          end
          if (is_last !== exp_w.last) begin
            $display("%0t: is_last mismatch: expected %0b, got %0b",
                     $time, exp_w.last, is_last);
            error_count++;
          end
          digits_checked++;
        end
      end
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Stimulus: reset, the directed rows, four random phases with different amounts of
  // idling on each side, and a drain before the verdict.
  initial begin
    error_count    = 0;
    words_sent     = 0;
    digits_checked = 0;
    for (int b = 0; b < 4; b++) words_per_base[b] = 0;
    snd_idle_pct   = 0;
    rcv_stall_pct  = 0;

    // Zero in every base, single digits, the boundaries between one and two digits, and
    // the extremes of the value range, both positive and most negative.
    dir_rows = '{
      '{32'h0000_0000, OP_BIN,  8'd1,  128'h0},
      '{32'h0000_0000, OP_OCT,  8'd1,  128'h0},
      '{32'h0000_0000, OP_DEC,  8'd1,  128'h0},
      '{32'h0000_0000, OP_HEX,  8'd1,  128'h0},
      '{32'h0000_0001, OP_BIN,  8'd1,  128'h1},
      '{32'hFFFF_FFFF, OP_HEX,  8'd1,  128'h1},
      '{32'hFFFF_FFFF, OP_BIN,  8'd1,  128'h1},
      '{32'h7FFF_FFFF, OP_HEX,  8'd8,  128'h7FFF_FFFF},
      '{32'h8000_0000, OP_HEX,  8'd8,  128'h8000_0000},
      '{32'h8000_0000, OP_DEC,  8'd10, 128'h21_4748_3648},
      '{32'h7FFF_FFFF, OP_DEC,  8'd10, 128'h21_4748_3647},
      '{32'h8000_0001, OP_DEC,  8'd10, 128'h21_4748_3647},
      '{32'h8000_0000, OP_OCT,  8'd11, 128'h200_0000_0000},
      '{32'h7FFF_FFFF, OP_OCT,  8'd11, 128'h177_7777_7777},
      '{32'h8000_0000, OP_BIN,  8'd32, 128'h1000_0000_0000_0000_0000_0000_0000_0000},
      '{32'h7FFF_FFFF, OP_BIN,  8'd0,  128'h0},
      '{32'h0000_0009, OP_DEC,  8'd1,  128'h9},
      '{32'h0000_000A, OP_DEC,  8'd2,  128'h10},
      '{32'hFFFF_FFF6, OP_DEC,  8'd2,  128'h10},
      '{32'h0000_000F, OP_HEX,  8'd1,  128'hF},
      '{32'h0000_0010, OP_HEX,  8'd2,  128'h10},
      '{32'h0000_0007, OP_OCT,  8'd1,  128'h7},
      '{32'h0000_0008, OP_OCT,  8'd2,  128'h10},
      '{32'h1234_5678, OP_DEC,  8'd0,  128'h0},
      '{32'hA5A5_A5A5, OP_OCT,  8'd0,  128'h0}
    };

    rst      <= 1'b1;
    in_valid <= 1'b0;
    value    <= '0;
    opcode   <= OP_BIN;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed words run with light idling on both sides.
    snd_idle_pct  = 20;
    rcv_stall_pct = 20;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_word(dir_rows[i].val, dir_rows[i].op);
      if (dir_rows[i].num_digits == 0) begin
        predict_digits(dir_rows[i].val, dir_rows[i].op);
      end else begin
        for (int k = 0; k < dir_rows[i].num_digits; k++) begin
          digit_word_t w;
          w.dig  = dir_rows[i].nibbles[4 * (dir_rows[i].num_digits - 1 - k) +: 4];
          w.last = (k == dir_rows[i].num_digits - 1);
          pending_digits.push_back(w);
        end
      end
    end
    in_valid <= 1'b0;

    // Between phases the sender waits for every digit to come back, so the block is
    // also seen starting from a completely quiet state.
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 56; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 56; end
        default: begin snd_idle_pct = 24; rcv_stall_pct = 24; end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        logic [VALUE_W-1:0]  v;
        logic [OPCODE_W-1:0] op;
        v  = pick_value();
        op = OPCODE_W'($urandom_range(3));
        send_word(v, op);
        predict_digits(v, op);
      end
      in_valid <= 1'b0;
    end

    // Let any late or surplus words show themselves before judging.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (binary %0d, octal %0d, decimal %0d, hexadecimal %0d).",
             words_sent, words_per_base[OP_BIN], words_per_base[OP_OCT],
             words_per_base[OP_DEC], words_per_base[OP_HEX]);
    $display("Checked %0d digits under four idling mixes; %0d mismatches, %0d left awaited.",
             digits_checked, error_count, pending_digits.size());
    if (error_count == 0 && pending_digits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rdc_pkg.sv
rtl/rdc_ram.sv
rtl/rdc_divider.sv
rtl/radix_digit_converter_top.sv
tb/tb_radix_digit_converter_top.sv
